// ===== hw/rtl/tpsrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsrm_pkg
// Shared types and constants for the three-phase serial register master.
// ----------------------------------------------------------------------------
package tpsrm_pkg;

   localparam int MAX_LENGTH   = 32;
   localparam int ADDRESS_BITS = 4;
   localparam int WORD_W       = 32;
   localparam int LEN_W        = 6;
   localparam int BIT_W        = 6;
   localparam int WORD_IDX_W   = 5;
   localparam int ADDR_IDX_W   = 2;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 40;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      CK_IDLE,
      CK_START,
      CK_BITS,
      CK_FINISH
   } ck_state_type;

   typedef enum logic [2:0] {
      DT_IDLE,
      DT_START,
      DT_DIR,
      DT_ADDR,
      DT_WRITE,
      DT_READ,
      DT_FINISH
   } dt_state_type;

   typedef struct packed {
      logic                  opcode;
      logic                  direction;
      logic [3:0]            reg_address;
      logic [WORD_W-1:0]     write_data;
      logic [LEN_W-1:0]      transfer_length;
      logic                  data_in;
   } tpsrm_item_type;

   typedef struct packed {
      logic                  clock_line;
      logic                  data_line;
      logic                  data_drive_enable;
      logic                  busy_res;
      logic [WORD_W-1:0]     read_result;
      logic                  transfer_done;
   } tpsrm_result_type;

   typedef struct packed {
      ck_state_type              ck_state;
      dt_state_type              dt_state;
      logic [1:0]                ck_count;
      logic [BIT_W-1:0]          ck_bits;
      logic [1:0]                dt_phase;
      logic [BIT_W-1:0]          dt_bit;
      logic                      busy;
      logic                      direction;
      logic [ADDRESS_BITS-1:0]   address;
      logic [WORD_W-1:0]         write_word;
      logic [LEN_W-1:0]          length;
      logic [WORD_W-1:0]         read_word;
      logic                      data_level;
      logic                      drive_level;
      logic                      clock_level;
   } tpsrm_state_type;

endpackage

// ===== hw/rtl/tpsrm_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsrm_step
// Next-state and result logic for one item: clock and data phase machines.
// ----------------------------------------------------------------------------
module tpsrm_step
   import tpsrm_pkg::*;
(
   input  tpsrm_state_type  cur_state,
   input  tpsrm_item_type   item,
   output tpsrm_state_type  nxt_state,
   output tpsrm_result_type result
);

   logic                   done;
   logic [LEN_W-1:0]       len_clamped;
   logic [1:0]             phase_inc;
   logic [BIT_W-1:0]       bit_inc;
   logic                   at_end;
   logic [WORD_IDX_W-1:0]  word_pos;
   logic [ADDR_IDX_W-1:0]  addr_pos;

   always_comb begin
      nxt_state   = cur_state;
      done        = 1'b0;
      len_clamped = (item.transfer_length > LEN_W'(MAX_LENGTH)) ?
                    LEN_W'(MAX_LENGTH) : item.transfer_length;
      if (cur_state.dt_phase == 2'd2) begin
         phase_inc = 2'd0;
         bit_inc   = cur_state.dt_bit + BIT_W'(1);
      end else begin
         phase_inc = cur_state.dt_phase + 2'd1;
         bit_inc   = cur_state.dt_bit;
      end
      at_end   = (cur_state.dt_bit == cur_state.length) && (cur_state.dt_phase == 2'd0);
      word_pos = WORD_IDX_W'(cur_state.length - LEN_W'(1) - cur_state.dt_bit);
      addr_pos = ADDR_IDX_W'(ADDRESS_BITS - 1) - cur_state.dt_bit[ADDR_IDX_W-1:0];

      if (item.opcode == OP_START) begin
         nxt_state.direction   = item.direction;
         nxt_state.address     = item.reg_address[ADDRESS_BITS-1:0];
         nxt_state.write_word  = item.write_data;
         nxt_state.length      = len_clamped;
         nxt_state.busy        = 1'b1;
         nxt_state.ck_count    = 2'd0;
         nxt_state.ck_bits     = '0;
         nxt_state.dt_phase    = 2'd0;
         nxt_state.dt_bit      = '0;
         nxt_state.drive_level = 1'b1;
         nxt_state.ck_state    = CK_START;
         nxt_state.dt_state    = DT_START;
      end else begin
         // clock machine, sees the data state before it moves
         case (cur_state.ck_state)
            CK_START: begin
               if (cur_state.ck_count == 2'd2) begin
                  nxt_state.clock_level = 1'b0;
                  nxt_state.ck_count    = 2'd0;
                  nxt_state.ck_state    = CK_BITS;
               end else begin
                  nxt_state.clock_level = 1'b1;
                  nxt_state.ck_count    = cur_state.ck_count + 2'd1;
               end
            end
            CK_BITS: begin
               nxt_state.clock_level = (cur_state.ck_count == 2'd1);
               if (cur_state.ck_count == 2'd2) begin
                  nxt_state.ck_count = 2'd0;
                  if (cur_state.ck_bits == BIT_W'(ADDRESS_BITS) + BIT_W'(cur_state.length)) begin
                     nxt_state.ck_bits  = '0;
                     nxt_state.ck_state = CK_FINISH;
                  end else begin
                     nxt_state.ck_bits = cur_state.ck_bits + BIT_W'(1);
                  end
                  if (cur_state.dt_state == DT_READ) begin
                     nxt_state.clock_level = 1'b1;
                  end
               end else begin
                  nxt_state.ck_count = cur_state.ck_count + 2'd1;
               end
            end
            CK_FINISH: begin
               nxt_state.clock_level = (cur_state.ck_count == 2'd1) ||
                                       (cur_state.ck_count == 2'd2);
               if (cur_state.ck_count == 2'd3) begin
                  nxt_state.ck_count = 2'd0;
                  nxt_state.ck_state = CK_IDLE;
               end else begin
                  nxt_state.ck_count = cur_state.ck_count + 2'd1;
               end
            end
            default: begin
            end
         endcase

         // data machine
         case (cur_state.dt_state)
            DT_START: begin
               nxt_state.data_level = (cur_state.dt_phase == 2'd0);
               nxt_state.dt_phase   = phase_inc;
               if (cur_state.dt_phase == 2'd2) begin
                  nxt_state.dt_bit   = '0;
                  nxt_state.dt_state = DT_DIR;
               end
            end
            DT_DIR: begin
               nxt_state.data_level = cur_state.direction;
               nxt_state.dt_phase   = phase_inc;
               if (cur_state.dt_phase == 2'd2) begin
                  nxt_state.dt_bit   = '0;
                  nxt_state.dt_state = DT_ADDR;
               end
            end
            DT_ADDR: begin
               nxt_state.data_level = cur_state.address[addr_pos];
               nxt_state.dt_phase   = phase_inc;
               nxt_state.dt_bit     = bit_inc;
               if ((cur_state.dt_bit == BIT_W'(ADDRESS_BITS - 1)) &&
                   (cur_state.dt_phase == 2'd2)) begin
                  nxt_state.dt_bit   = '0;
                  nxt_state.dt_state = cur_state.direction ? DT_READ : DT_WRITE;
               end
            end
            DT_WRITE: begin
               if (at_end) begin
                  nxt_state.data_level = 1'b0;
                  nxt_state.dt_phase   = 2'd0;
                  nxt_state.dt_bit     = '0;
                  nxt_state.dt_state   = DT_FINISH;
               end else begin
                  nxt_state.data_level = cur_state.write_word[word_pos];
                  nxt_state.dt_phase   = phase_inc;
                  nxt_state.dt_bit     = bit_inc;
               end
            end
            DT_READ: begin
               if ((cur_state.dt_bit == '0) && (cur_state.dt_phase == 2'd0)) begin
                  nxt_state.read_word   = '0;
                  nxt_state.drive_level = 1'b0;
               end
               if ((cur_state.dt_bit < cur_state.length) && (cur_state.dt_phase == 2'd2) &&
                   item.data_in) begin
                  nxt_state.read_word[word_pos] = 1'b1;
               end
               if (at_end) begin
                  nxt_state.dt_phase = 2'd0;
                  nxt_state.dt_bit   = '0;
                  nxt_state.dt_state = DT_FINISH;
               end else begin
                  nxt_state.dt_phase = phase_inc;
                  nxt_state.dt_bit   = bit_inc;
               end
            end
            DT_FINISH: begin
               if (cur_state.dt_phase == 2'd0) begin
                  nxt_state.data_level  = 1'b0;
                  nxt_state.drive_level = 1'b1;
               end else begin
                  nxt_state.data_level = 1'b1;
               end
               nxt_state.dt_phase = phase_inc;
               if (cur_state.dt_phase == 2'd2) begin
                  nxt_state.dt_bit   = '0;
                  nxt_state.dt_state = DT_IDLE;
               end
            end
            default: begin
            end
         endcase

         if ((nxt_state.ck_state == CK_IDLE) || (nxt_state.dt_state == DT_IDLE)) begin
            nxt_state.ck_state = CK_IDLE;
            nxt_state.dt_state = DT_IDLE;
            nxt_state.ck_count = 2'd0;
            nxt_state.ck_bits  = '0;
            nxt_state.dt_phase = 2'd0;
            nxt_state.dt_bit   = '0;
            done               = cur_state.busy;
            nxt_state.busy     = 1'b0;
         end
      end

      result.clock_line        = nxt_state.clock_level;
      result.data_line         = nxt_state.data_level;
      result.data_drive_enable = nxt_state.drive_level;
      result.busy_res          = nxt_state.busy;
      result.read_result       = nxt_state.read_word;
      result.transfer_done     = done;
   end

endmodule

// ===== hw/rtl/three_phase_serial_register_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_serial_register_master_core
// Each item goes through the input register, the step logic and the result register.
// Throughput: 1 item per cycle unless stalled; step logic is one pass between registers.
// Stalls on the result side hold the input register; ready stays high while it can drain.
// Reset: synchronous, active high; resets both phase machines, counters and latches.
// ----------------------------------------------------------------------------
module three_phase_serial_register_master_core
   import tpsrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // direction[0], reg_address[4:1], write_data[36:5], transfer_length[42:37],
   // data_in[43], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // clock_line[0], data_line[1], data_drive_enable[2], busy_res[3],
   // read_result[35:4], transfer_done[36], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              in_valid_ff;
   tpsrm_item_type    in_item_ff;
   tpsrm_item_type    in_item_in;
   logic              rsp_valid_ff;
   tpsrm_result_type  rsp_data_ff;
   tpsrm_result_type  step_result;
   tpsrm_state_type   state_ff;
   tpsrm_state_type   state_in;
   tpsrm_state_type   state_reset;
   logic              advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_item_in.opcode          = req_tuser[0];
   assign in_item_in.direction       = req_tdata[0];
   assign in_item_in.reg_address     = req_tdata[4:1];
   assign in_item_in.write_data      = req_tdata[36:5];
   assign in_item_in.transfer_length = req_tdata[42:37];
   assign in_item_in.data_in         = req_tdata[43];

   always_comb begin
      state_reset             = '0;
      state_reset.ck_state    = CK_IDLE;
      state_reset.dt_state    = DT_IDLE;
      state_reset.length      = LEN_W'(1);
      state_reset.drive_level = 1'b1;
   end

   tpsrm_step u_step (
      .cur_state (state_ff),
      .item      (in_item_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= state_reset;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.transfer_done,
                        rsp_data_ff.read_result,
                        rsp_data_ff.busy_res,
                        rsp_data_ff.data_drive_enable,
                        rsp_data_ff.data_line,
                        rsp_data_ff.clock_line};

endmodule
